// ----- rtl/fpa_pkg.sv -----
// Package for the fixed-point ALU: opcodes, widths and pipeline beat type.
// No dependencies.
`default_nettype none
package fpa_pkg;
  localparam int FracBits = 8;
  localparam int WordBits = 32;
  localparam int NumBits  = WordBits + FracBits;
  localparam int Stages   = NumBits;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_LT = 4'd4, OP_LE = 4'd5, OP_GT = 4'd6, OP_GE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
  } op_t;

  // One beat moving down the divider chain.
  typedef struct packed {
    logic                 vld;
    logic                 is_div;
    logic                 neg;
    logic                 fault;
    logic [NumBits-1:0]   quo;   // dividend bits shift out, quotient bits in
    logic [WordBits:0]    rem;
    logic [WordBits-1:0]  dvs;   // divisor magnitude
    logic [WordBits-1:0]  val;   // result of non-divide ops
    logic                 truth;
  } beat_t;
endpackage
`default_nettype wire

// ----- rtl/fpa_cell.sv -----
// One restoring-division cell: one quotient bit per cycle, registered.
// Depends on fpa_pkg.
`default_nettype none
module fpa_cell
  import fpa_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  beat_t din,
  output beat_t dout
);
  beat_t nxt;
  logic [WordBits:0] trial;
  logic [WordBits+1:0] diff;

  always_comb begin
    nxt = din;
    trial = {din.rem[WordBits-1:0], din.quo[NumBits-1]};
    diff = {1'b0, trial} - {2'b00, din.dvs};
    if (din.is_div) begin
      if (!diff[WordBits+1]) begin
        nxt.rem = diff[WordBits:0];
        nxt.quo = {din.quo[NumBits-2:0], 1'b1};
      end else begin
        nxt.rem = trial;
        nxt.quo = {din.quo[NumBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.is_div <= nxt.is_div;
    dout.neg    <= nxt.neg;
    dout.fault  <= nxt.fault;
    dout.quo    <= nxt.quo;
    dout.rem    <= nxt.rem;
    dout.dvs    <= nxt.dvs;
    dout.val    <= nxt.val;
    dout.truth  <= nxt.truth;
  end
endmodule
`default_nettype wire

// ----- rtl/fpa_front.sv -----
// Entry stage: decodes the op, computes all non-divide ops including the
// multiply, and sets up the divider. Depends on fpa_pkg.
`default_nettype none
module fpa_front
  import fpa_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire [3:0]           func,
  input  wire signed [31:0]   operand_a,
  input  wire signed [31:0]   operand_b,
  output beat_t               dout
);
  logic signed [WordBits-1:0] a, b;
  logic signed [2*WordBits-1:0] prod;
  logic [WordBits-1:0] mag_a, mag_b;
  beat_t nxt;
  op_t op;

  assign a = operand_a[WordBits-1:0];
  assign b = operand_b[WordBits-1:0];
  assign op = op_t'(func);
  assign prod = a * b;
  assign mag_a = a[WordBits-1] ? WordBits'(-a) : WordBits'(a);
  assign mag_b = b[WordBits-1] ? WordBits'(-b) : WordBits'(b);

  always_comb begin
    nxt = '0;
    nxt.vld = start;
    nxt.dvs = mag_b;
    case (op)
      OP_ADD:     nxt.val = a + b;
      OP_SUB:     nxt.val = a - b;
      OP_MUL:     nxt.val = prod[FracBits +: WordBits];
      OP_DIV: begin
        nxt.fault  = (b == '0);
        nxt.is_div = (b != '0);
        nxt.neg    = a[WordBits-1] ^ b[WordBits-1];
        nxt.quo    = {mag_a, {FracBits{1'b0}}};
      end
      OP_LT:      nxt.truth = a < b;
      OP_LE:      nxt.truth = a <= b;
      OP_GT:      nxt.truth = a > b;
      OP_GE:      nxt.truth = a >= b;
      OP_EQ:      nxt.truth = a == b;
      OP_NE:      nxt.truth = a != b;
      OP_MIN:     nxt.val = (a >= b) ? b : a;
      OP_MAX:     nxt.val = (a >= b) ? a : b;
      OP_INC:     nxt.val = a + WordBits'(1);
      OP_DEC:     nxt.val = a - WordBits'(1);
      OP_TOINT:   nxt.val = a >>> FracBits;
      default:    nxt.val = a << FracBits;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= nxt.vld;
    end
    dout.is_div <= nxt.is_div;
    dout.neg    <= nxt.neg;
    dout.fault  <= nxt.fault;
    dout.quo    <= nxt.quo;
    dout.rem    <= nxt.rem;
    dout.dvs    <= nxt.dvs;
    dout.val    <= nxt.val;
    dout.truth  <= nxt.truth;
  end
endmodule
`default_nettype wire

// ----- rtl/fixed_point_alu_unit.sv -----
// Top level of the fixed-point ALU: entry stage, divider cell chain, output.
// Depends on fpa_pkg, fpa_front, fpa_cell.
//
// channel | ports                                   | handshake
// in      | func, operand_a, operand_b              | start & !busy
// out     | value, truth, divide_fault              | done (one cycle)
//
// One item per cycle; every op passes the entry stage, the restoring divider
// chain (Q24.8, one quotient bit per cell) and the output register.
// busy is always low. Reset clears the valid bits. The receiver cannot stall.
`default_nettype none
module fixed_point_alu_unit
  import fpa_pkg::*;
(
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  output logic              busy,
  input  wire [3:0]         func,
  input  wire signed [31:0] operand_a,
  input  wire signed [31:0] operand_b,
  output logic              done,
  output logic signed [31:0] value,
  output logic              truth,
  output logic              divide_fault
);
  beat_t chain [Stages+1];
  logic [WordBits-1:0] q, res;

  assign busy = 1'b0;

  fpa_front u_front (.clk, .rst, .start, .func, .operand_a, .operand_b,
                     .dout(chain[0]));

  for (genvar i = 0; i < Stages; i++) begin : g_cell
    fpa_cell u_cell (.clk, .rst, .din(chain[i]), .dout(chain[i+1]));
  end

  assign q = chain[Stages].quo[WordBits-1:0];
  always_comb begin
    if (chain[Stages].fault) begin
      res = '0;
    end else if (chain[Stages].is_div) begin
      res = chain[Stages].neg ? -q : q;
    end else begin
      res = chain[Stages].val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[Stages].vld;
    end
    value        <= 32'(signed'(res));
    truth        <= chain[Stages].truth;
    divide_fault <= chain[Stages].fault;
  end
endmodule
`default_nettype wire

// ----- rtl/fpa_checker.sv -----
// Port checker for the fixed-point ALU, bound to the top level.
// Depends on fpa_pkg.
`default_nettype none
module fpa_checker
  import fpa_pkg::*;
(
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire        busy,
  input wire        done,
  input wire [31:0] value,
  input wire        truth,
  input wire        divide_fault
);
  localparam int Lat = Stages + 2;

  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, Lat)) else $error("done without beat");
  a_fault: assert property (@(posedge clk) disable iff (rst)
    done && divide_fault |-> value == 32'd0 && !truth) else $error("fault value");
  a_truth: assert property (@(posedge clk) disable iff (rst)
    done && truth |-> value == 32'd0) else $error("truth value");
endmodule

bind fixed_point_alu_unit fpa_checker u_chk (.clk, .rst, .start, .busy, .done,
  .value, .truth, .divide_fault);
`default_nettype wire

// ----- test/fixed_point_alu_unit_tb.sv -----
// Testbench for fixed_point_alu_unit: drives opcode/operand beats, predicts each
// result in SystemVerilog and checks it against the done strobe in order.
// Depends on fpa_pkg and the fixed_point_alu_unit RTL.
`default_nettype none

class alu_scoreboard;
  typedef struct {
    logic signed [31:0] value;
    logic               truth;
    logic               fault;
  } alu_result_t;

  alu_result_t pending[$];
  int          mismatches;

  // Q24.8 arithmetic; the fraction width comes from the package
  function void note_beat(fpa_pkg::op_t op, logic signed [31:0] a, logic signed [31:0] b);
    alu_result_t r;
    logic signed [63:0] prod;
    logic signed [63:0] num;
    logic signed [63:0] quo;
    r.value = '0;
    r.truth = 1'b0;
    r.fault = 1'b0;
    case (op)
      fpa_pkg::OP_ADD: r.value = a + b;
      fpa_pkg::OP_SUB: r.value = a - b;
      fpa_pkg::OP_MUL: begin
        prod = 64'(a) * 64'(b);
        r.value = 32'(prod >>> fpa_pkg::FracBits);
      end
      fpa_pkg::OP_DIV: begin
        if (b == 0) begin
          r.fault = 1'b1;
        end else begin
          num = 64'(a) <<< fpa_pkg::FracBits;
          quo = num / 64'(b);
          r.value = 32'(quo);
        end
      end
      fpa_pkg::OP_LT: r.truth = a < b;
      fpa_pkg::OP_LE: r.truth = a <= b;
      fpa_pkg::OP_GT: r.truth = a > b;
      fpa_pkg::OP_GE: r.truth = a >= b;
      fpa_pkg::OP_EQ: r.truth = a == b;
      fpa_pkg::OP_NE: r.truth = a != b;
      fpa_pkg::OP_MIN: r.value = (a >= b) ? b : a;
      fpa_pkg::OP_MAX: r.value = (a >= b) ? a : b;
      fpa_pkg::OP_INC: r.value = a + 32'sd1;
      fpa_pkg::OP_DEC: r.value = a - 32'sd1;
      fpa_pkg::OP_TOINT: r.value = a >>> fpa_pkg::FracBits;
      default: r.value = a <<< fpa_pkg::FracBits;
    endcase
    pending.push_back(r);
  endfunction

  function void check_result(logic signed [31:0] value, logic truth, logic fault);
    alu_result_t r;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result value=%h truth=%b fault=%b",
                                     value, truth, fault);
      return;
    end
    r = pending.pop_front();
    if (value !== r.value || truth !== r.truth || fault !== r.fault) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp value=%h truth=%b fault=%b got value=%h truth=%b fault=%b",
                 r.value, r.truth, r.fault, value, truth, fault);
    end
  endfunction
endclass

module fixed_point_alu_unit_tb
  import fpa_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = NumBits + 2;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [3:0]         func = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic               done;
  logic signed [31:0] value;
  logic               truth;
  logic               divide_fault;

  alu_scoreboard sb = new();
  bit            calm;

  fixed_point_alu_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .operand_a(operand_a), .operand_b(operand_b), .done(done), .value(value),
    .truth(truth), .divide_fault(divide_fault)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(value, truth, divide_fault);
  end

  // one beat; start stays high across back-to-back beats
  task automatic send_beat(op_t op, logic signed [31:0] a, logic signed [31:0] b);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    func      <= op;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy);
    sb.note_beat(op, a, b);
  endtask

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return $signed(32'($urandom_range(0, 1023)) - 32'd512);
      4: return $signed(32'($urandom_range(0, 1 << 20)) - 32'd524288);
      default: return $signed($urandom());
    endcase
  endfunction

  initial begin
    logic signed [31:0] a;
    logic signed [31:0] b;
    int waited;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // every op on corners, including divide by zero and the most negative word
    for (int k = 0; k < 16; k++) begin
      send_beat(op_t'(k), 32'sh8000_0000, 32'sh7fff_ffff);
    end
    send_beat(OP_DIV, 32'sh0000_0100, 32'sh0);
    send_beat(OP_DIV, 32'sh8000_0000, 32'shffff_ffff);
    send_beat(OP_DIV, -32'sh0000_0300, 32'sh0000_0200);
    send_beat(OP_MIN, 32'sh0000_0500, 32'sh0000_0500);
    send_beat(OP_MAX, -32'sh1, -32'sh1);
    send_beat(OP_TOINT, -32'sh1, 32'sh0);
    send_beat(OP_MUL, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_beat(OP_EQ, 32'sh1234_5678, 32'sh1234_5678);
    for (int n = 0; n < 1000; n++) begin
      calm = (n > 850);
      a = pick_operand();
      b = ($urandom_range(0, 15) == 0) ? a : pick_operand();
      send_beat(op_t'($urandom_range(0, 15)), a, b);
    end
    start <= 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < 10 * Latency) begin
      @(posedge clk);
      waited++;
    end
    repeat (Latency + 4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

`default_nettype wire

// ----- fixed_point_alu_unit.f -----
rtl/fpa_pkg.sv
rtl/fpa_cell.sv
rtl/fpa_front.sv
rtl/fixed_point_alu_unit.sv
rtl/fpa_checker.sv
test/fixed_point_alu_unit_tb.sv
